FILE: rtl/tscs_pkg.sv
`timescale 1ns / 1ps
// Package of the transactional shadow call stack: beat types, command and status codes,
// entry kinds, sequencer states and the controller/datapath command and status structs.
// No dependencies.
package tscs_pkg;

   localparam int DEF_THREADS       = 16;
   localparam int DEF_STACK_ENTRIES = 512;
   localparam int ADDR_W            = 48;
   localparam int KIND_W            = 2;
   localparam int ENTRY_W           = ADDR_W + KIND_W;
   localparam int DEPTH_OUT_W       = 10;

   localparam logic [2:0] CMD_CALL   = 3'd0;
   localparam logic [2:0] CMD_RET    = 3'd1;
   localparam logic [2:0] CMD_BEGIN  = 3'd2;
   localparam logic [2:0] CMD_COMMIT = 3'd3;
   localparam logic [2:0] CMD_ABORT  = 3'd4;
   localparam logic [2:0] CMD_START  = 3'd5;
   localparam logic [2:0] CMD_FORK   = 3'd6;
   localparam logic [2:0] CMD_RSVD   = 3'd7;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_ABORT_NOTXN = 3'd1;
   localparam logic [2:0] ST_FORK_IN_TXN = 3'd2;
   localparam logic [2:0] ST_OVERFLOW    = 3'd3;
   localparam logic [2:0] ST_NOT_STARTED = 3'd4;

   localparam logic [KIND_W-1:0] KIND_CALL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RET   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd2;

   typedef struct packed {
      logic [2:0]        cmd;
      logic [3:0]        thread;
      logic [3:0]        parent_thread;
      logic [ADDR_W-1:0] target_addr;
      logic              is_sigreturn;
   } req_type;

   typedef struct packed {
      logic [2:0]             status;
      logic [DEPTH_OUT_W-1:0] stack_depth;
      logic                   in_transaction;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_RET_TEST,
      S_RET_CHK,
      S_RET_REC,
      S_CMT_TEST,
      S_CMT_CHK,
      S_COPY_RD,
      S_COPY_WR,
      S_FORK_FIN,
      S_FIN
   } state_type;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LOAD,
      DP_STATUS,
      DP_CALL,
      DP_BEGIN,
      DP_ABORT,
      DP_START,
      DP_RET_INIT,
      DP_RET_READ,
      DP_RET_POP,
      DP_RET_STEP,
      DP_RET_REC,
      DP_CMT_INIT,
      DP_CMT_READ,
      DP_CMT_CALL,
      DP_CMT_RET,
      DP_CMT_SKIP,
      DP_FORK_INIT,
      DP_COPY_READ,
      DP_COPY_WRITE,
      DP_FORK_FIN,
      DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic       sel_parent;
      logic [2:0] code;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       sig;
      logic       t_ok;
      logic       p_ok;
      logic       same;
      logic       live;
      logic       open;
      logic       full;
      logic       sidx_zero;
      logic       sidx_full;
      logic       is_call;
      logic       is_ret;
      logic       match;
      logic       r_done;
      logic       rsp_busy;
   } stat_type;

endpackage

FILE: rtl/transactional_shadow_call_stack.sv
`timescale 1ns / 1ps
// Top level of the transactional shadow call stack: joins the sequencer and the datapath.
// Depends on tscs_pkg, tscs_ctrl and tscs_datapath.
//
// One request beat on req_* carries a command (call, return, transaction begin, commit,
// abort, thread start, fork) for one thread; every request gives exactly one response beat
// on rsp_* with a status, the thread's stack depth afterwards and its transaction flag.
// Requests are taken one at a time: req_ready is high only while the block is idle and
// the response register is empty.
// Call, begin, abort, start, sigreturn, unknown commands and the error cases go straight
// from decode to the response. A return reads the stack entries one at a time from the top
// and, when it finds no match, records itself. A commit replays the entries above the mark,
// with a search for each replayed return. A fork onto itself skips the copy; any other fork
// copies the parent's entries one by one. The single entry memory does one registered read
// and one write per cycle. The next request is taken only once the response beat has
// been accepted.
// Reset clears the live and transaction flags of all threads and the response valid flag;
// the entry memory is not cleared and needs no pass after reset.
// While the receiver holds rsp_ready low, the response stays in its register and no new
// request is taken.
module transactional_shadow_call_stack
   import tscs_pkg::*;
#(
   parameter int THREADS       = DEF_THREADS,
   parameter int STACK_ENTRIES = DEF_STACK_ENTRIES
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_type  ctl;
   stat_type stat;

   tscs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   tscs_datapath #(
      .THREADS       (THREADS),
      .STACK_ENTRIES (STACK_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .stat      (stat)
   );

endmodule

FILE: rtl/tscs_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the shadow call stack: decodes the request and steps the datapath
// through searches, replays and copies. Depends on tscs_pkg.
module tscs_ctrl
   import tscs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output ctl_type  ctl
);

   state_type state_ff, state_in;
   logic      in_cmt_ff, in_cmt_in;
   state_type ret_back;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         in_cmt_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         in_cmt_ff <= in_cmt_in;
      end
   end

   assign ret_back = in_cmt_ff ? S_CMT_TEST : S_FIN;

   always_comb begin
      state_in       = state_ff;
      in_cmt_in      = in_cmt_ff;
      ctl.op         = DP_NONE;
      ctl.sel_parent = 1'b0;
      ctl.code       = ST_OK;
      req_ready      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !stat.rsp_busy;
            if (req_valid && !stat.rsp_busy) begin
               ctl.op   = DP_LOAD;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.sel_parent = (stat.cmd == CMD_FORK);
            state_in       = S_FIN;
            in_cmt_in      = 1'b0;
            if (stat.cmd <= CMD_ABORT && (!stat.t_ok || !stat.live)) begin
               ctl.op   = DP_STATUS;
               ctl.code = ST_NOT_STARTED;
            end else begin
               unique case (stat.cmd)
                  CMD_CALL: begin
                     if (stat.full) begin
                        ctl.op   = DP_STATUS;
                        ctl.code = ST_OVERFLOW;
                     end else begin
                        ctl.op = DP_CALL;
                     end
                  end
                  CMD_RET: begin
                     if (!stat.sig) begin
                        ctl.op   = DP_RET_INIT;
                        state_in = S_RET_TEST;
                     end
                  end
                  CMD_BEGIN: begin
                     if (!stat.open) begin
                        if (stat.full) begin
                           ctl.op   = DP_STATUS;
                           ctl.code = ST_OVERFLOW;
                        end else begin
                           ctl.op = DP_BEGIN;
                        end
                     end
                  end
                  CMD_COMMIT: begin
                     if (stat.open) begin
                        ctl.op   = DP_CMT_INIT;
                        state_in = S_CMT_TEST;
                     end
                  end
                  CMD_ABORT: begin
                     if (stat.open) begin
                        ctl.op = DP_ABORT;
                     end else begin
                        ctl.op   = DP_STATUS;
                        ctl.code = ST_ABORT_NOTXN;
                     end
                  end
                  CMD_START: begin
                     if (!stat.t_ok) begin
                        ctl.op   = DP_STATUS;
                        ctl.code = ST_NOT_STARTED;
                     end else if (!stat.live) begin
                        ctl.op = DP_START;
                     end
                  end
                  CMD_FORK: begin
                     if (!stat.t_ok || !stat.p_ok || !stat.live) begin
                        ctl.op   = DP_STATUS;
                        ctl.code = ST_NOT_STARTED;
                     end else if (stat.open) begin
                        ctl.op   = DP_STATUS;
                        ctl.code = ST_FORK_IN_TXN;
                     end else begin
                        ctl.op   = DP_FORK_INIT;
                        state_in = stat.same ? S_FORK_FIN : S_COPY_RD;
                     end
                  end
                  default: begin
                     ctl.op = DP_NONE;
                  end
               endcase
            end
         end
         S_RET_TEST: begin
            if (stat.sidx_zero) begin
               state_in = S_RET_REC;
            end else begin
               ctl.op   = DP_RET_READ;
               state_in = S_RET_CHK;
            end
         end
         S_RET_CHK: begin
            if (!stat.is_call) begin
               state_in = S_RET_REC;
            end else if (stat.match) begin
               ctl.op   = DP_RET_POP;
               state_in = ret_back;
            end else begin
               ctl.op   = DP_RET_STEP;
               state_in = S_RET_TEST;
            end
         end
         S_RET_REC: begin
            if (stat.sidx_full) begin
               ctl.op   = DP_STATUS;
               ctl.code = ST_OVERFLOW;
            end else begin
               ctl.op = DP_RET_REC;
            end
            state_in = ret_back;
         end
         S_CMT_TEST: begin
            if (stat.r_done) begin
               state_in = S_FIN;
            end else begin
               ctl.op   = DP_CMT_READ;
               state_in = S_CMT_CHK;
            end
         end
         S_CMT_CHK: begin
            if (stat.is_call) begin
               ctl.op   = DP_CMT_CALL;
               state_in = S_CMT_TEST;
            end else if (stat.is_ret) begin
               ctl.op    = DP_CMT_RET;
               in_cmt_in = 1'b1;
               state_in  = S_RET_TEST;
            end else begin
               ctl.op   = DP_CMT_SKIP;
               state_in = S_CMT_TEST;
            end
         end
         S_COPY_RD: begin
            if (stat.r_done) begin
               state_in = S_FORK_FIN;
            end else begin
               ctl.op   = DP_COPY_READ;
               state_in = S_COPY_WR;
            end
         end
         S_COPY_WR: begin
            ctl.op   = DP_COPY_WRITE;
            state_in = S_COPY_RD;
         end
         S_FORK_FIN: begin
            ctl.op   = DP_FORK_FIN;
            state_in = S_FIN;
         end
         S_FIN: begin
            ctl.op   = DP_FINISH;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/tscs_datapath.sv
`timescale 1ns / 1ps
// Datapath of the shadow call stack: request and response registers, per-thread
// pointers and flags, and the entry memory. Depends on tscs_pkg.
module tscs_datapath
   import tscs_pkg::*;
#(
   parameter int THREADS       = DEF_THREADS,
   parameter int STACK_ENTRIES = DEF_STACK_ENTRIES
) (
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   output rsp_type  rsp_data,
   input  ctl_type  ctl,
   output stat_type stat
);

   localparam int TIDX_W    = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int IDX_W     = $clog2(STACK_ENTRIES);
   localparam int DEPTH_W   = $clog2(STACK_ENTRIES + 1);
   localparam int MEM_AW    = TIDX_W + IDX_W;
   localparam int MEM_DEPTH = THREADS * (2 ** IDX_W);

   req_type                 req_ff;
   logic [2:0]              status_ff;
   rsp_type                 rsp_ff;
   logic                    rsp_valid_ff;
   logic [DEPTH_W-1:0]      sp_ff   [THREADS];
   logic [DEPTH_W-1:0]      mark_ff [THREADS];
   logic [THREADS-1:0]      open_ff;
   logic [THREADS-1:0]      live_ff;
   logic [ADDR_W-1:0]       key_ff;
   logic [DEPTH_W-1:0]      sidx_ff;
   logic [DEPTH_W-1:0]      ridx_ff;
   logic [DEPTH_W-1:0]      rend_ff;
   logic [ENTRY_W-1:0]      mem [MEM_DEPTH];
   logic [ENTRY_W-1:0]      rdata_ff;

   logic [TIDX_W-1:0]       tidx;
   logic [TIDX_W-1:0]       pidx;
   logic [TIDX_W-1:0]       sel;
   logic                    t_ok;
   logic [DEPTH_W-1:0]      sp_rd;
   logic [DEPTH_W-1:0]      mark_rd;
   logic [DEPTH_W-1:0]      sidx_dec;
   logic [KIND_W-1:0]       rd_kind;

   logic                    mem_we;
   logic [MEM_AW-1:0]       mem_waddr;
   logic [ENTRY_W-1:0]      mem_wdata;
   logic                    mem_re;
   logic [MEM_AW-1:0]       mem_raddr;

   logic                    sp_we;
   logic [DEPTH_W-1:0]      sp_wdata;
   logic                    mark_we;
   logic [DEPTH_W-1:0]      mark_wdata;
   logic                    open_we;
   logic                    open_wdata;
   logic                    live_set;

   assign tidx     = TIDX_W'(req_ff.thread);
   assign pidx     = TIDX_W'(req_ff.parent_thread);
   assign sel      = ctl.sel_parent ? pidx : tidx;
   assign t_ok     = 32'(req_ff.thread) < THREADS;
   assign sp_rd    = sp_ff[sel];
   assign mark_rd  = mark_ff[tidx];
   assign sidx_dec = sidx_ff - 1'b1;
   assign rd_kind  = rdata_ff[ENTRY_W-1 -: KIND_W];

   assign stat.cmd       = req_ff.cmd;
   assign stat.sig       = req_ff.is_sigreturn;
   assign stat.t_ok      = t_ok;
   assign stat.p_ok      = 32'(req_ff.parent_thread) < THREADS;
   assign stat.same      = req_ff.thread == req_ff.parent_thread;
   assign stat.live      = live_ff[sel];
   assign stat.open      = open_ff[sel];
   assign stat.full      = sp_rd >= DEPTH_W'(STACK_ENTRIES);
   assign stat.sidx_zero = sidx_ff == '0;
   assign stat.sidx_full = sidx_ff >= DEPTH_W'(STACK_ENTRIES);
   assign stat.is_call   = rd_kind == KIND_CALL;
   assign stat.is_ret    = rd_kind == KIND_RET;
   assign stat.match     = rdata_ff[ADDR_W-1:0] == key_ff;
   assign stat.r_done    = ridx_ff >= rend_ff;
   assign stat.rsp_busy  = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      mem_we     = 1'b0;
      mem_waddr  = {tidx, sp_rd[IDX_W-1:0]};
      mem_wdata  = {KIND_CALL, req_ff.target_addr};
      mem_re     = 1'b0;
      mem_raddr  = {tidx, sidx_dec[IDX_W-1:0]};
      sp_we      = 1'b0;
      sp_wdata   = sp_rd + 1'b1;
      mark_we    = 1'b0;
      mark_wdata = '0;
      open_we    = 1'b0;
      open_wdata = 1'b0;
      live_set   = 1'b0;
      case (ctl.op)
         DP_CALL: begin
            mem_we = 1'b1;
            sp_we  = 1'b1;
         end
         DP_BEGIN: begin
            mem_we     = 1'b1;
            mem_wdata  = {KIND_BEGIN, {ADDR_W{1'b0}}};
            sp_we      = 1'b1;
            mark_we    = 1'b1;
            mark_wdata = sp_rd;
            open_we    = 1'b1;
            open_wdata = 1'b1;
         end
         DP_ABORT: begin
            sp_we    = 1'b1;
            sp_wdata = mark_rd;
            open_we  = 1'b1;
         end
         DP_START: begin
            sp_we    = 1'b1;
            sp_wdata = '0;
            mark_we  = 1'b1;
            open_we  = 1'b1;
            live_set = 1'b1;
         end
         DP_RET_READ: begin
            mem_re = 1'b1;
         end
         DP_RET_POP: begin
            sp_we    = 1'b1;
            sp_wdata = sidx_dec;
         end
         DP_RET_REC: begin
            mem_we    = 1'b1;
            mem_waddr = {tidx, sidx_ff[IDX_W-1:0]};
            mem_wdata = {KIND_RET, key_ff};
            sp_we     = 1'b1;
            sp_wdata  = sidx_ff + 1'b1;
         end
         DP_CMT_INIT: begin
            sp_we    = 1'b1;
            sp_wdata = mark_rd;
            open_we  = 1'b1;
         end
         DP_CMT_READ: begin
            mem_re    = 1'b1;
            mem_raddr = {tidx, ridx_ff[IDX_W-1:0]};
         end
         DP_CMT_CALL: begin
            mem_we    = 1'b1;
            mem_wdata = {KIND_CALL, rdata_ff[ADDR_W-1:0]};
            sp_we     = 1'b1;
         end
         DP_COPY_READ: begin
            mem_re    = 1'b1;
            mem_raddr = {pidx, ridx_ff[IDX_W-1:0]};
         end
         DP_COPY_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = {tidx, ridx_ff[IDX_W-1:0]};
            mem_wdata = rdata_ff;
         end
         DP_FORK_FIN: begin
            sp_we    = 1'b1;
            sp_wdata = rend_ff;
            mark_we  = 1'b1;
            open_we  = 1'b1;
            live_set = 1'b1;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   // Pointers and marks need no reset: a thread that is not live reads as empty.
   always_ff @(posedge clock) begin
      if (sp_we) begin
         sp_ff[tidx] <= sp_wdata;
      end
      if (mark_we) begin
         mark_ff[tidx] <= mark_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (open_we) begin
            open_ff[tidx] <= open_wdata;
         end
         if (live_set) begin
            live_ff[tidx] <= 1'b1;
         end
         if (ctl.op == DP_FINISH) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (ctl.op)
         DP_LOAD: begin
            req_ff    <= req_data;
            status_ff <= ST_OK;
         end
         DP_STATUS: begin
            status_ff <= ctl.code;
         end
         DP_RET_INIT: begin
            key_ff  <= req_ff.target_addr;
            sidx_ff <= sp_rd;
         end
         DP_RET_STEP: begin
            sidx_ff <= sidx_dec;
         end
         DP_CMT_INIT: begin
            rend_ff <= sp_rd;
            ridx_ff <= mark_rd + 1'b1;
         end
         DP_CMT_CALL, DP_CMT_SKIP, DP_COPY_WRITE: begin
            ridx_ff <= ridx_ff + 1'b1;
         end
         DP_CMT_RET: begin
            key_ff  <= rdata_ff[ADDR_W-1:0];
            sidx_ff <= sp_rd;
            ridx_ff <= ridx_ff + 1'b1;
         end
         DP_FORK_INIT: begin
            rend_ff <= sp_rd;
            ridx_ff <= '0;
         end
         DP_FINISH: begin
            rsp_ff.status         <= status_ff;
            rsp_ff.stack_depth    <= (t_ok && live_ff[tidx]) ?
                                     DEPTH_OUT_W'(sp_ff[tidx]) : '0;
            rsp_ff.in_transaction <= t_ok && open_ff[tidx];
         end
         default: begin
            key_ff <= key_ff;
         end
      endcase
   end

endmodule

FILE: rtl/tscs_checker.sv
`timescale 1ns / 1ps
// Port checker of the transactional shadow call stack, bound to the top level.
// Depends on tscs_pkg.
module tscs_checker
   import tscs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A response beat that is not taken holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Only one request is in flight at a time.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status <= ST_NOT_STARTED)
      else $error("status code out of range");

   // An abort refused for lack of a transaction cannot report an open one.
   a_abort_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_ABORT_NOTXN |-> !rsp_data.in_transaction)
      else $error("abort outside transaction reports open transaction");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind transactional_shadow_call_stack tscs_checker u_tscs_checker (.*);

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the transactional shadow call stack.
// Depends on tscs_pkg and transactional_shadow_call_stack; a behavioral predictor of the
// per-thread stacks supplies the expected response of every request beat.
module tb_top;
   import tscs_pkg::*;

   localparam int NTHR = DEF_THREADS;
   localparam int NENT = DEF_STACK_ENTRIES;
   localparam int CYCLE_LIMIT = 20000000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   transactional_shadow_call_stack uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Predictor state: one shadow stack per thread.
   logic [ENTRY_W-1:0] shadow_mem [NTHR][NENT];
   int unsigned        shadow_depth [NTHR];
   int unsigned        shadow_mark  [NTHR];
   bit                 shadow_open  [NTHR];
   bit                 shadow_live  [NTHR];

   rsp_type     pending_rsp [$];
   int unsigned error_count;
   int unsigned rsp_count;
   int unsigned cycle_count;
   bit          quiet_mode;
   int unsigned hold_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("transactional_shadow_call_stack regression: fail");
            $finish;
         end
      end
   end

   function automatic logic [2:0] push_call(int t, logic [ADDR_W-1:0] a);
      if (shadow_depth[t] >= NENT) return ST_OVERFLOW;
      shadow_mem[t][shadow_depth[t]] = {KIND_CALL, a};
      shadow_depth[t]++;
      return ST_OK;
   endfunction

   function automatic logic [2:0] pop_return(int t, logic [ADDR_W-1:0] a);
      int unsigned i;
      logic [ENTRY_W-1:0] e;
      i = shadow_depth[t];
      while (i > 0) begin
         e = shadow_mem[t][i-1];
         if (e[ENTRY_W-1:ADDR_W] != KIND_CALL) break;
         if (e[ADDR_W-1:0] == a) begin
            shadow_depth[t] = i - 1;
            return ST_OK;
         end
         i--;
      end
      if (i >= NENT) return ST_OVERFLOW;
      shadow_mem[t][i] = {KIND_RET, a};
      shadow_depth[t] = i + 1;
      return ST_OK;
   endfunction

   function automatic rsp_type predict_rsp(req_type r);
      rsp_type o;
      int t, p;
      int unsigned old, k, d;
      logic [2:0] st;
      logic [ENTRY_W-1:0] e;
      logic [2:0] dummy;
      t = int'(r.thread);
      p = int'(r.parent_thread);
      st = ST_OK;
      if (r.cmd <= CMD_ABORT) begin
         if (!shadow_live[t]) st = ST_NOT_STARTED;
         else begin
            case (r.cmd)
               CMD_CALL: st = push_call(t, r.target_addr);
               CMD_RET: if (!r.is_sigreturn) st = pop_return(t, r.target_addr);
               CMD_BEGIN: if (!shadow_open[t]) begin
                  d = shadow_depth[t];
                  st = push_call(t, '0);
                  if (st == ST_OK) begin
                     shadow_mem[t][d] = {KIND_BEGIN, {ADDR_W{1'b0}}};
                     shadow_mark[t] = d;
                     shadow_open[t] = 1'b1;
                  end
               end
               CMD_COMMIT: if (shadow_open[t]) begin
                  old = shadow_depth[t];
                  shadow_depth[t] = shadow_mark[t];
                  for (k = shadow_mark[t] + 1; k < old; k++) begin
                     e = shadow_mem[t][k];
                     if (e[ENTRY_W-1:ADDR_W] == KIND_CALL)
                        dummy = push_call(t, e[ADDR_W-1:0]);
                     else if (e[ENTRY_W-1:ADDR_W] == KIND_RET)
                        dummy = pop_return(t, e[ADDR_W-1:0]);
                  end
                  shadow_open[t] = 1'b0;
               end
               default: begin
                  if (!shadow_open[t]) st = ST_ABORT_NOTXN;
                  else begin
                     shadow_depth[t] = shadow_mark[t];
                     shadow_open[t] = 1'b0;
                  end
               end
            endcase
         end
      end else if (r.cmd == CMD_START) begin
         if (!shadow_live[t]) begin
            shadow_live[t] = 1'b1;
            shadow_depth[t] = 0;
            shadow_mark[t] = 0;
            shadow_open[t] = 1'b0;
         end
      end else if (r.cmd == CMD_FORK) begin
         if (!shadow_live[p]) st = ST_NOT_STARTED;
         else if (shadow_open[p]) st = ST_FORK_IN_TXN;
         else begin
            if (t != p)
               for (k = 0; k < shadow_depth[p]; k++) shadow_mem[t][k] = shadow_mem[p][k];
            shadow_depth[t] = shadow_depth[p];
            shadow_mark[t] = 0;
            shadow_open[t] = 1'b0;
            shadow_live[t] = 1'b1;
         end
      end
      o.status = st;
      o.stack_depth = shadow_depth[t][DEPTH_OUT_W-1:0];
      o.in_transaction = shadow_open[t];
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0d expected %0d", rsp_count, what, got, want);
      error_count++;
   endtask

   // Response checker and receiver idling.
   initial begin
      rsp_type want;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.stack_depth != want.stack_depth)
                  report_mismatch("stack_depth", rsp_data.stack_depth, want.stack_depth);
               if (rsp_data.in_transaction != want.in_transaction)
                  report_mismatch("in_transaction", rsp_data.in_transaction,
                                  want.in_transaction);
            end
            rsp_count++;
         end
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ready <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 9) == 0) begin
            hold_cycles = $urandom_range(1, 15);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Sends one beat; the expectation is formed when it is accepted. Valid stays high
   // into the next beat unless the sender idles or drains.
   task automatic send_req(req_type r);
      if (!quiet_mode && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(predict_rsp(r));
      @(negedge clock);
   endtask

   task automatic send_cmd(logic [2:0] c, int t, logic [ADDR_W-1:0] a = '0,
                           bit sig = 0, int p = 0);
      req_type r;
      r.cmd = c; r.thread = 4'(t); r.parent_thread = 4'(p); r.target_addr = a;
      r.is_sigreturn = sig;
      send_req(r);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_rsp.size() != 0);
   endtask

   task automatic test_directed;
      send_cmd(CMD_CALL, 3, 48'h123);          // thread not started
      send_cmd(CMD_ABORT, 3);
      send_cmd(CMD_FORK, 4, 0, 0, 3);          // parent not live
      send_cmd(CMD_START, 0);
      send_cmd(CMD_START, 0);                  // restart is a no-op
      send_cmd(CMD_CALL, 0, '1);
      send_cmd(CMD_CALL, 0, '0);
      send_cmd(CMD_CALL, 0, 48'h5555_aaaa_0f0f);
      send_cmd(CMD_RET, 0, '1, 1);             // sigreturn ignored
      send_cmd(CMD_RET, 0, '1);                // pops down through the match
      send_cmd(CMD_RET, 0, 48'h777);           // no match, recorded at bottom
      send_cmd(CMD_ABORT, 0);                  // abort outside transaction
      send_cmd(CMD_COMMIT, 0);                 // commit outside transaction
      send_cmd(CMD_BEGIN, 0);
      send_cmd(CMD_BEGIN, 0);                  // nested begin
      send_cmd(CMD_CALL, 0, 48'haaaa_5555_f0f0);
      send_cmd(CMD_RET, 0, 48'h999);
      send_cmd(CMD_FORK, 1, 0, 0, 0);          // fork in transaction
      send_cmd(CMD_COMMIT, 0);
      send_cmd(CMD_FORK, 15, 0, 0, 0);
      send_cmd(CMD_FORK, 15, 0, 0, 15);        // fork onto itself
      send_cmd(CMD_BEGIN, 15);
      send_cmd(CMD_CALL, 15, 48'h1);
      send_cmd(CMD_ABORT, 15);
      send_cmd(CMD_RSVD, 15);                  // unknown command
      drain();
   endtask

   task automatic test_overflow;
      int i;
      send_cmd(CMD_START, 2);
      for (i = 0; i < NENT; i++) send_cmd(CMD_CALL, 2, i + 48'h1000);
      send_cmd(CMD_CALL, 2, 48'h1);
      send_cmd(CMD_BEGIN, 2);
      send_cmd(CMD_RET, 2, 48'h2);             // no match in a full stack, recorded at bottom
      send_cmd(CMD_RET, 2, 48'h1000 + NENT - 1);
      send_cmd(CMD_BEGIN, 2);
      send_cmd(CMD_RET, 2, 48'h1000);          // search stops at the marker
      send_cmd(CMD_COMMIT, 2);
      send_cmd(CMD_RET, 2, 48'h1000);          // search stops at once at a recorded return
      drain();
   endtask

   // Receiver holds off for a long stretch while requests keep coming.
   task automatic test_backpressure;
      int i;
      hold_cycles = 300;
      for (i = 0; i < 10; i++) send_cmd(CMD_CALL, 5, 48'(i), 0, 0);
      drain();
   endtask

   function automatic req_type rand_req;
      req_type r;
      int unsigned sel;
      r.thread = 4'($urandom_range(0, 7) == 0 ? $urandom_range(0, 15)
                                              : $urandom_range(0, 5));
      r.parent_thread = 4'($urandom_range(0, 15) < 12 ? $urandom_range(0, 5) : $urandom());
      r.target_addr = $urandom_range(0, 3) == 0 ? 48'({$urandom(), $urandom()})
                                                : 48'(1 + $urandom_range(0, 7));
      r.is_sigreturn = $urandom_range(0, 15) == 0;
      sel = $urandom_range(0, 99);
      if (sel < 38)      r.cmd = CMD_CALL;
      else if (sel < 68) r.cmd = CMD_RET;
      else if (sel < 76) r.cmd = CMD_BEGIN;
      else if (sel < 84) r.cmd = CMD_COMMIT;
      else if (sel < 88) r.cmd = CMD_ABORT;
      else if (sel < 93) r.cmd = CMD_START;
      else if (sel < 98) r.cmd = CMD_FORK;
      else               r.cmd = CMD_RSVD;
      return r;
   endfunction

   task automatic test_random(int n);
      int i;
      for (i = 0; i < n; i++) send_req(rand_req());
      drain();
   endtask

   initial begin
      int t;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      error_count = 0;
      rsp_count = 0;
      quiet_mode = 0;
      hold_cycles = 0;
      for (t = 0; t < NTHR; t++) begin
         shadow_depth[t] = 0; shadow_mark[t] = 0;
         shadow_open[t] = 0; shadow_live[t] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random(700);
      quiet_mode = 1;
      test_random(250);
      repeat (50) @(negedge clock);
      $display("covered %0d responses: directed corner cases, full-stack overflow,", rsp_count);
      $display("long receiver stalls and random call/return/transaction/fork traffic");
      if (error_count == 0) begin
         $display("transactional_shadow_call_stack regression: pass");
      end else begin
         $display("transactional_shadow_call_stack regression: fail");
      end
      $finish;
   end

endmodule
